// File: design/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/narc_pkg.sv
package narc_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE          = 3'd0,
      MODE_SEND_DATA     = 3'd1,
      MODE_WAIT_ACK      = 3'd2,
      MODE_SEND_FAIL     = 3'd3,
      MODE_CAPACITY      = 3'd4,
      MODE_WAIT_JOIN     = 3'd5,
      MODE_WAIT_ADDR     = 3'd6,
      MODE_WAIT_JOIN_ACK = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_CLKRST    = 3'd1,
      EV_DIRECTIVE = 3'd2,
      EV_MEAS      = 3'd3,
      EV_FAIL      = 3'd4,
      EV_ACK       = 3'd5,
      EV_JOIN      = 3'd6,
      EV_UNUSED    = 3'd7
   } event_type;

   typedef enum logic [2:0] {
      KIND_NONE = 3'd0,
      KIND_ACK  = 3'd1,
      KIND_DATA = 3'd2,
      KIND_FAIL = 3'd3,
      KIND_JOIN = 3'd4
   } kind_type;

   localparam int CsrIndexW = 1;
   localparam int CsrDataW  = 16;
   localparam logic [CsrIndexW-1:0] CSR_ACK_TIMEOUT  = 1'd0;
   localparam logic [CsrIndexW-1:0] CSR_MAX_ATTEMPTS = 1'd1;

   localparam logic [15:0] ACK_TIMEOUT_RESET  = 16'd1000;
   localparam logic [3:0]  MAX_ATTEMPTS_RESET = 4'd3;
   localparam logic [15:0] AGE_MAX            = 16'hFFFF;

   typedef struct packed {
      logic [2:0] new_event;
      logic       tick;
      logic       addr_ok;
      logic       line_busy;
   } req_type;

   typedef struct packed {
      mode_type ctl_state;
      kind_type send_kind;
      logic     take_directive;
      logic     clock_restart;
      logic     clear_sample;
      logic     gave_up;
      logic     address_reset;
      logic     joined;
   } rsp_type;

endpackage

// File: design/node_ack_retry_controller.sv
// channel  | direction | handshake            | word
// req      | in        | req_valid/req_stall  | req_type: event, tick, addr_ok, line_busy
// rsp      | out       | rsp_valid/rsp_stall  | rsp_type: state, send kind, pulses, joined
// csr      | in        | csr_we               | index 0 ack_timeout_ms, 1 max_attempts
//
// One poll per clock unless req_stall holds it; its word appears in the result register in the cycle after accept.
// The state update is a single pass of compare and increment logic on the state registers.
// Synchronous active-high reset clears state, restores register defaults, empties rsp.
// req_stall follows rsp_stall only while a result word waits in the result register.
module node_ack_retry_controller import narc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata
);

   logic [15:0] ack_timeout_ff;
   logic [3:0]  max_attempts_ff;

   mode_type    mode_ff, mode_in;
   event_type   latch_ff, latch_in;
   logic [3:0]  attempt_ff, attempt_in;
   logic [15:0] age_ff, age_in;
   logic        joined_ff, joined_in;

   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        accept;
   event_type   ev;
   logic [15:0] age_tick;
   logic        timeout;
   logic        can_retry;
   kind_type    retry_kind;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_timeout_ff  <= ACK_TIMEOUT_RESET;
         max_attempts_ff <= MAX_ATTEMPTS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ACK_TIMEOUT:  ack_timeout_ff  <= csr_wdata;
            CSR_MAX_ATTEMPTS: max_attempts_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      ev = (req_data.new_event != EV_NONE) ? event_type'(req_data.new_event) : latch_ff;
      age_tick = (req_data.tick && age_ff != AGE_MAX) ? age_ff + 16'd1 : age_ff;
      timeout = age_tick >= ack_timeout_ff;
      can_retry = attempt_ff < max_attempts_ff;

      mode_in    = mode_ff;
      latch_in   = ev;
      attempt_in = attempt_ff;
      age_in     = age_tick;
      joined_in  = joined_ff;
      retry_kind = KIND_NONE;
      rsp_data_in = '0;

      unique case (mode_ff)
         MODE_IDLE: begin
            latch_in = EV_NONE;
            unique case (ev)
               EV_CLKRST: rsp_data_in.clock_restart = 1'b1;
               EV_DIRECTIVE: begin
                  rsp_data_in.take_directive = 1'b1;
                  mode_in = MODE_WAIT_ACK;
                  age_in = '0;
                  attempt_in = 4'd1;
                  rsp_data_in.send_kind = KIND_ACK;
               end
               EV_MEAS: begin
                  mode_in = MODE_SEND_DATA;
                  age_in = '0;
                  attempt_in = 4'd1;
                  rsp_data_in.send_kind = KIND_DATA;
               end
               EV_FAIL: begin
                  mode_in = MODE_SEND_FAIL;
                  age_in = '0;
                  attempt_in = 4'd1;
                  rsp_data_in.send_kind = KIND_FAIL;
               end
               default: ;
            endcase
         end
         MODE_SEND_DATA, MODE_WAIT_ACK, MODE_SEND_FAIL: begin
            unique case (mode_ff)
               MODE_SEND_DATA: retry_kind = KIND_DATA;
               MODE_WAIT_ACK:  retry_kind = KIND_ACK;
               default:        retry_kind = KIND_FAIL;
            endcase
            if (timeout && can_retry) begin
               age_in = '0;
               rsp_data_in.send_kind = retry_kind;
               attempt_in = attempt_ff + 4'd1;
            end
            if (timeout && !can_retry) begin
               mode_in = MODE_IDLE;
               latch_in = EV_NONE;
               rsp_data_in.gave_up = 1'b1;
               rsp_data_in.clear_sample = (mode_ff == MODE_SEND_DATA);
            end else if (ev == EV_ACK) begin
               mode_in = MODE_IDLE;
               latch_in = EV_NONE;
               rsp_data_in.clear_sample = (mode_ff == MODE_SEND_DATA);
            end
         end
         MODE_CAPACITY: ;
         MODE_WAIT_JOIN: begin
            if (ev == EV_JOIN) begin
               latch_in = EV_NONE;
               if (!req_data.line_busy) begin
                  rsp_data_in.send_kind = KIND_JOIN;
                  age_in = '0;
                  mode_in = MODE_WAIT_ADDR;
               end
            end
         end
         MODE_WAIT_ADDR: begin
            if (timeout) begin
               age_in = '0;
               mode_in = MODE_WAIT_JOIN;
            end
            if (ev == EV_JOIN) begin
               latch_in = EV_NONE;
               if (req_data.addr_ok) begin
                  mode_in = MODE_WAIT_JOIN_ACK;
                  age_in = '0;
                  joined_in = 1'b1;
                  rsp_data_in.send_kind = KIND_ACK;
               end else begin
                  mode_in = MODE_WAIT_JOIN;
               end
            end
         end
         MODE_WAIT_JOIN_ACK: begin
            if (timeout) begin
               mode_in = MODE_WAIT_JOIN;
               latch_in = EV_NONE;
               joined_in = 1'b0;
               rsp_data_in.address_reset = 1'b1;
            end else begin
               mode_in = MODE_CAPACITY;
            end
         end
      endcase

      rsp_data_in.ctl_state = mode_in;
      rsp_data_in.joined    = joined_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         latch_ff     <= EV_NONE;
         attempt_ff   <= '0;
         age_ff       <= '0;
         joined_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff    <= mode_in;
            latch_ff   <= latch_in;
            attempt_ff <= attempt_in;
            age_ff     <= age_in;
            joined_ff  <= joined_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: design/narc_checker.sv
`include "assert_macros.svh"

module narc_checker import narc_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input rsp_type              rsp_data
);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "rsp word changed while stalled")
   `ASSERT_CLK(a_req_gives_rsp, clock, reset, req_valid && !req_stall |=> rsp_valid, "accepted poll produced no rsp word")
   `ASSERT_CLK(a_directive_ack, clock, reset, rsp_valid && rsp_data.take_directive |-> rsp_data.send_kind == KIND_ACK && rsp_data.ctl_state == MODE_WAIT_ACK, "directive without ack send")
   `ASSERT_CLK(a_gave_up_idle, clock, reset, rsp_valid && rsp_data.gave_up |-> rsp_data.ctl_state == MODE_IDLE && rsp_data.send_kind == KIND_NONE, "give up left block busy")

endmodule

bind node_ack_retry_controller narc_checker u_narc_checker (.*);
